/* rtl/tsdt_pkg.sv */
package tsdt_pkg;

   // table geometry
   localparam int TABLE_ENTRIES = 32;
   localparam int TLS_FIRST     = 6;
   localparam int TLS_LAST      = 8;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int TLS_HI        = (TLS_LAST < TABLE_ENTRIES) ? TLS_LAST : TABLE_ENTRIES - 1;

   localparam logic [31:0] EMPTY_FLAGS = 32'h0000_0028;

   // request kinds
   localparam logic [1:0] REQ_SET_AREA = 2'd0;
   localparam logic [1:0] REQ_GET_AREA = 2'd1;
   localparam logic [1:0] REQ_LDT_CALL = 2'd2;
   localparam logic [1:0] REQ_LOOKUP   = 2'd3;

   // ldt call function codes
   localparam logic [31:0] LDT_FN_READ      = 32'h0000_0000;
   localparam logic [31:0] LDT_FN_WRITE_OLD = 32'h0000_0001;
   localparam logic [31:0] LDT_FN_WRITE     = 32'h0000_0011;
   localparam logic [31:0] LDT_WRITE_BYTES  = 32'd16;

   // result status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_FAULT   = 3'd1;
   localparam logic [2:0] ST_INVALID = 3'd2;
   localparam logic [2:0] ST_NOSLOT  = 3'd3;
   localparam logic [2:0] ST_UNSUP   = 3'd4;

   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [31:0] entry_req;
      logic [31:0]        seg_base;
      logic [31:0]        seg_limit;
      logic [31:0]        seg_flags;
      logic [31:0]        ldt_func;
      logic [31:0]        byte_budget;
      logic               buffer_fault;
      logic [15:0]        selector;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [5:0]  entry_out;
      logic [9:0]  bytes_written;
      logic [31:0] base_out;
      logic [19:0] limit_out;
      logic [31:0] flags_out;
      logic [31:0] word_low;
      logic [31:0] word_high;
      logic        words_valid;
      logic        last;
   } rsp_item_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DECODE,
      S_EMIT,
      S_STREAM
   } state_type;

   // what the decoded request turns into
   typedef enum logic [0:0] {
      ACT_SINGLE,
      ACT_STREAM
   } action_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic emit_single;
      logic emit_stream;
   } ctrl_cmd_type;

   typedef struct packed {
      action_type action;
      logic       stream_last;
   } dp_status_type;

endpackage

/* rtl/tsdt_ctrl.sv */
module tsdt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   out_free,
   input  tsdt_pkg::dp_status_type dp_status,
   output logic                   req_stall,
   output tsdt_pkg::ctrl_cmd_type cmd
);

   tsdt_pkg::state_type state_ff;
   tsdt_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tsdt_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tsdt_pkg::S_IDLE: begin
            if (req_valid) state_in = tsdt_pkg::S_DECODE;
         end
         tsdt_pkg::S_DECODE: begin
            if (dp_status.action == tsdt_pkg::ACT_STREAM) state_in = tsdt_pkg::S_STREAM;
            else state_in = tsdt_pkg::S_EMIT;
         end
         tsdt_pkg::S_EMIT: begin
            if (out_free) state_in = tsdt_pkg::S_IDLE;
         end
         tsdt_pkg::S_STREAM: begin
            if (out_free && dp_status.stream_last) state_in = tsdt_pkg::S_IDLE;
         end
         default: state_in = tsdt_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         tsdt_pkg::S_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         tsdt_pkg::S_DECODE: begin
            cmd.exec = 1'b1;
         end
         tsdt_pkg::S_EMIT: begin
            cmd.emit_single = out_free;
         end
         tsdt_pkg::S_STREAM: begin
            cmd.emit_stream = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

/* rtl/tsdt_datapath.sv */
module tsdt_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  tsdt_pkg::req_item_type req_item,
   input  tsdt_pkg::ctrl_cmd_type cmd,
   output tsdt_pkg::dp_status_type dp_status,
   output tsdt_pkg::rsp_item_type rsp_next
);

   localparam int IW = tsdt_pkg::IDX_W;

   typedef enum logic [1:0] {
      KIND_PLAIN,
      KIND_GET,
      KIND_LOOKUP
   } kind_type;

   // descriptor storage
   logic [31:0] mem_base  [tsdt_pkg::TABLE_ENTRIES];
   logic [19:0] mem_limit [tsdt_pkg::TABLE_ENTRIES];
   logic [31:0] mem_flags [tsdt_pkg::TABLE_ENTRIES];
   logic [tsdt_pkg::TABLE_ENTRIES-1:0] slot_used_ff;

   logic [31:0] rd_base_ff;
   logic [19:0] rd_limit_ff;
   logic [31:0] rd_flags_ff;

   tsdt_pkg::req_item_type req_ff;

   // single-result context
   logic [2:0]  sgl_status_ff, sgl_status_in;
   logic [5:0]  sgl_entry_ff, sgl_entry_in;
   kind_type    sgl_kind_ff, sgl_kind_in;
   logic        sgl_hit_ff, sgl_hit_in;

   // ldt read stream
   logic [IW-1:0] ent_ff;
   logic [IW-1:0] last_ff, last_in;
   logic [IW:0]   ent_p1;

   // decode
   logic          is_empty, minus_one, in_tls, in_table, found;
   logic [IW-1:0] free_idx, ent_idx, wr_idx, rd_idx, dec_rd_idx;
   logic          wr_en, rd_en, dec_rd;
   logic [12:0]   lk_idx;
   logic          lk_hit;
   tsdt_pkg::action_type dec_action;

   function automatic logic [63:0] encode(input logic [31:0] b, input logic [19:0] l,
                                          input logic [31:0] f);
      logic [31:0] lo;
      logic [31:0] hi;
      lo = {b[15:0], l[15:0]};
      hi = {b[31:24], f[4], f[0], 1'b0, f[6], l[19:16], ~f[5], 3'b111,
            f[2:1], ~f[3], 1'b0, b[23:16]};
      return {hi, lo};
   endfunction

   assign ent_idx  = req_ff.entry_req[IW-1:0];
   assign is_empty = (req_ff.seg_base == 32'd0) && (req_ff.seg_limit == 32'd0)
                     && (req_ff.seg_flags == tsdt_pkg::EMPTY_FLAGS);
   assign minus_one = (req_ff.entry_req == -32'sd1);
   assign in_tls    = (req_ff.entry_req >= tsdt_pkg::TLS_FIRST)
                      && (req_ff.entry_req <= tsdt_pkg::TLS_HI);
   assign in_table  = (req_ff.entry_req >= 0)
                      && (req_ff.entry_req < tsdt_pkg::TABLE_ENTRIES);
   assign lk_idx    = req_ff.selector[15:3];
   assign lk_hit    = (req_ff.selector[15:2] != 14'd0)
                      && (lk_idx < tsdt_pkg::TABLE_ENTRIES)
                      && slot_used_ff[lk_idx[IW-1:0]];

   // first free tls slot, lowest index wins
   always_comb begin
      found    = 1'b0;
      free_idx = '0;
      for (int c = tsdt_pkg::TLS_HI; c >= tsdt_pkg::TLS_FIRST; c--) begin
         if (!slot_used_ff[c]) begin
            found    = 1'b1;
            free_idx = IW'(c);
         end
      end
   end

   always_comb begin
      sgl_status_in = tsdt_pkg::ST_OK;
      sgl_entry_in  = '0;
      sgl_kind_in   = KIND_PLAIN;
      sgl_hit_in    = 1'b0;
      wr_en         = 1'b0;
      wr_idx        = ent_idx;
      dec_rd        = 1'b0;
      dec_rd_idx    = ent_idx;
      last_in       = '0;
      dec_action    = tsdt_pkg::ACT_SINGLE;
      case (req_ff.req_type)
         tsdt_pkg::REQ_SET_AREA: begin
            if (req_ff.buffer_fault) sgl_status_in = tsdt_pkg::ST_FAULT;
            else if (minus_one && is_empty) sgl_status_in = tsdt_pkg::ST_INVALID;
            else if (minus_one && !found) sgl_status_in = tsdt_pkg::ST_NOSLOT;
            else if (!minus_one && !in_tls) sgl_status_in = tsdt_pkg::ST_INVALID;
            else begin
               wr_en        = 1'b1;
               wr_idx       = minus_one ? free_idx : ent_idx;
               sgl_entry_in = 6'(wr_idx);
            end
         end
         tsdt_pkg::REQ_GET_AREA: begin
            if (req_ff.buffer_fault) sgl_status_in = tsdt_pkg::ST_FAULT;
            else if (!in_tls) sgl_status_in = tsdt_pkg::ST_INVALID;
            else begin
               dec_rd       = 1'b1;
               sgl_entry_in = 6'(ent_idx);
               sgl_kind_in  = KIND_GET;
               sgl_hit_in   = slot_used_ff[ent_idx];
            end
         end
         tsdt_pkg::REQ_LDT_CALL: begin
            if (req_ff.ldt_func == tsdt_pkg::LDT_FN_READ) begin
               if (req_ff.byte_budget == 32'd0) sgl_status_in = tsdt_pkg::ST_OK;
               else if (req_ff.buffer_fault) sgl_status_in = tsdt_pkg::ST_FAULT;
               else if (req_ff.byte_budget[31:3] == 29'd0) sgl_status_in = tsdt_pkg::ST_OK;
               else begin
                  dec_action = tsdt_pkg::ACT_STREAM;
                  dec_rd     = 1'b1;
                  dec_rd_idx = '0;
                  if (req_ff.byte_budget[31:3] >= tsdt_pkg::TABLE_ENTRIES)
                     last_in = IW'(tsdt_pkg::TABLE_ENTRIES - 1);
                  else
                     last_in = req_ff.byte_budget[IW+2:3] - IW'(1);
               end
            end else if (req_ff.ldt_func != tsdt_pkg::LDT_FN_WRITE_OLD
                         && req_ff.ldt_func != tsdt_pkg::LDT_FN_WRITE) begin
               sgl_status_in = tsdt_pkg::ST_UNSUP;
            end else if (req_ff.byte_budget != tsdt_pkg::LDT_WRITE_BYTES) begin
               sgl_status_in = tsdt_pkg::ST_INVALID;
            end else if (req_ff.buffer_fault) begin
               sgl_status_in = tsdt_pkg::ST_FAULT;
            end else if (!in_table) begin
               sgl_status_in = tsdt_pkg::ST_INVALID;
            end else begin
               wr_en        = 1'b1;
               sgl_entry_in = 6'(ent_idx);
            end
         end
         default: begin
            dec_rd       = 1'b1;
            dec_rd_idx   = lk_idx[IW-1:0];
            sgl_entry_in = lk_idx[5:0];
            sgl_kind_in  = KIND_LOOKUP;
            sgl_hit_in   = lk_hit;
         end
      endcase
   end

   assign ent_p1 = {1'b0, ent_ff} + (IW+1)'(1);
   assign dp_status = '{action: dec_action, stream_last: (ent_ff == last_ff)};

   assign rd_en  = (cmd.exec && dec_rd) || (cmd.emit_stream && !dp_status.stream_last);
   assign rd_idx = cmd.exec ? dec_rd_idx : ent_p1[IW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_item;
      if (cmd.exec) begin
         sgl_status_ff <= sgl_status_in;
         sgl_entry_ff  <= sgl_entry_in;
         sgl_kind_ff   <= sgl_kind_in;
         sgl_hit_ff    <= sgl_hit_in;
         last_ff       <= last_in;
      end
      if (cmd.exec) ent_ff <= '0;
      else if (cmd.emit_stream) ent_ff <= ent_p1[IW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_used_ff <= '0;
      end else if (cmd.exec && wr_en) begin
         slot_used_ff[wr_idx] <= !is_empty;
      end
   end

   // descriptor memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (cmd.exec && wr_en) begin
         mem_base[wr_idx]  <= is_empty ? 32'd0 : req_ff.seg_base;
         mem_limit[wr_idx] <= is_empty ? 20'd0 : req_ff.seg_limit[19:0];
         mem_flags[wr_idx] <= is_empty ? tsdt_pkg::EMPTY_FLAGS : req_ff.seg_flags;
      end
      if (rd_en) begin
         rd_base_ff  <= mem_base[rd_idx];
         rd_limit_ff <= mem_limit[rd_idx];
         rd_flags_ff <= mem_flags[rd_idx];
      end
   end

   always_comb begin
      logic [63:0] words;
      words    = encode(rd_base_ff, rd_limit_ff, rd_flags_ff);
      rsp_next = '0;
      if (cmd.emit_stream) begin
         rsp_next.status        = tsdt_pkg::ST_OK;
         rsp_next.entry_out     = 6'(ent_ff);
         rsp_next.bytes_written = 10'({ent_p1, 3'b000});
         if (slot_used_ff[ent_ff]) begin
            rsp_next.word_low  = words[31:0];
            rsp_next.word_high = words[63:32];
         end
         rsp_next.words_valid = 1'b1;
         rsp_next.last        = dp_status.stream_last;
      end else begin
         rsp_next.status    = sgl_status_ff;
         rsp_next.entry_out = sgl_entry_ff;
         rsp_next.last      = 1'b1;
         case (sgl_kind_ff)
            KIND_GET: begin
               rsp_next.base_out  = sgl_hit_ff ? rd_base_ff : 32'd0;
               rsp_next.limit_out = sgl_hit_ff ? rd_limit_ff : 20'd0;
               rsp_next.flags_out = sgl_hit_ff ? rd_flags_ff : tsdt_pkg::EMPTY_FLAGS;
            end
            KIND_LOOKUP: begin
               rsp_next.base_out = sgl_hit_ff ? rd_base_ff : 32'd0;
            end
            default: begin
               rsp_next.base_out = 32'd0;
            end
         endcase
      end
   end

endmodule

/* rtl/tls_segment_descriptor_table.sv */
// thread-local-storage segment descriptor table
//
// req channel: one request item (set/get thread area, ldt call, segment base
// lookup) moves when req_valid is high and req_stall is low. rsp channel: result
// items in the same valid/stall form; the final item of a request has last set.
// requests are handled one at a time: req_stall stays high from the cycle after
// an item is taken until its last result has been loaded into the output register.
// a request is captured, decoded with one table read or write, and its first
// result then loaded into the output register. a single-result request ends there;
// an ldt read then streams its entries, paced by the descriptor memory read port
// (one registered read per cycle, paused while the output register is not free).
// a result held by rsp_stall keeps the output register full; the table walk
// pauses until the receiver takes it, so nothing is dropped or repeated.
// reset clears the slot-used flags at once; the descriptor words themselves are
// never used for a slot that is not marked used, so they need no clearing.
module tls_segment_descriptor_table (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tsdt_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tsdt_pkg::rsp_item_type rsp_item
);

   tsdt_pkg::ctrl_cmd_type  cmd;
   tsdt_pkg::dp_status_type dp_status;
   tsdt_pkg::rsp_item_type  rsp_next;

   // output register
   logic                   rsp_valid_ff;
   tsdt_pkg::rsp_item_type rsp_item_ff;
   logic                   out_free;
   logic                   out_load;

   // the register may take a new item when empty or when its item leaves now
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign out_load = cmd.emit_single || cmd.emit_stream;

   tsdt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .dp_status (dp_status),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   tsdt_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .dp_status (dp_status),
      .rsp_next  (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // payload holds while stalled since a load only happens when out_free
   always_ff @(posedge clock) begin
      if (out_load) rsp_item_ff <= rsp_next;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

/* sim/testbench.sv */
module testbench;
   import tsdt_pkg::*;

   // run limits
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_ITEMS = 230;
   localparam int SHOW_LIMIT = 10;
   // item counts that bound the stretch with no idling on either side
   localparam int QUIET_FROM = 120;
   localparam int QUIET_TO = 180;
   // long receiver hold-off, started once enough items have been taken
   localparam int HOLD_AFTER = 40;
   localparam int HOLD_CYCLES = 160;
   localparam int DRAIN_CYCLES = 20;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_item_type req_item = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_item_type rsp_item;

   // items still to be offered, and results still owed by the block
   req_item_type pending_reqs[$];
   rsp_item_type awaited_results[$];

   // shadow descriptor table
   logic tbl_used [TABLE_ENTRIES];
   logic [31:0] tbl_base [TABLE_ENTRIES];
   logic [19:0] tbl_limit [TABLE_ENTRIES];
   logic [31:0] tbl_flags [TABLE_ENTRIES];

   int n_taken = 0;
   int fail_count = 0;
   int shown = 0;
   int cycle_count = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   tls_segment_descriptor_table dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // both sides run without gaps while this many items have been taken
   function automatic bit idling_allowed();
      return n_taken < QUIET_FROM || n_taken >= QUIET_TO;
   endfunction

   // empty user descriptor: clears the slot instead of installing it
   function automatic bit is_clear_desc(logic [31:0] b, logic [31:0] l, logic [31:0] f);
      return b == 32'd0 && l == 32'd0 && f == EMPTY_FLAGS;
   endfunction

   function automatic bit in_tls_range(int e);
      return e >= TLS_FIRST && e <= TLS_LAST && e < TABLE_ENTRIES;
   endfunction

   // 8-byte hardware descriptor built from a stored slot, {high, low}
   function automatic logic [63:0] encode_desc(logic [31:0] b, logic [19:0] l,
                                               logic [31:0] f);
      logic [31:0] lo;
      logic [31:0] hi;
      lo = {b[15:0], l[15:0]};
      // granularity, default size, avl, limit high, present, dpl 3 and s bit,
      // type from contents, writable unless read-exec-only
      hi = {b[31:24], f[4], f[0], 1'b0, f[6], l[19:16], ~f[5], 3'b111, f[2:1], ~f[3],
            1'b0, b[23:16]};
      return {hi, lo};
   endfunction

   function automatic void store_slot(int e, logic [31:0] b, logic [31:0] l,
                                      logic [31:0] f);
      if (is_clear_desc(b, l, f)) begin
         tbl_used[e]  = 1'b0;
         tbl_base[e]  = '0;
         tbl_limit[e] = '0;
         tbl_flags[e] = EMPTY_FLAGS;
      end else begin
         tbl_used[e]  = 1'b1;
         tbl_base[e]  = b;
         tbl_limit[e] = l[19:0];
         tbl_flags[e] = f;
      end
   endfunction

   // one-result answer; the slot number is only reported on success
   function automatic void owe_single(logic [2:0] st, int ent, logic [31:0] b,
                                      logic [19:0] l, logic [31:0] f);
      rsp_item_type r;
      r = '0;
      r.status    = st;
      r.entry_out = (st == ST_OK) ? ent[5:0] : 6'd0;
      r.base_out  = b;
      r.limit_out = l;
      r.flags_out = f;
      r.last      = 1'b1;
      awaited_results.push_back(r);
   endfunction

   // updates the shadow table and queues the results one request causes
   function automatic void compute_table_results(req_item_type rq);
      int e;
      int idx;
      int n_ent;
      bit clear_req;
      logic [63:0] words;
      rsp_item_type r;
      e = rq.entry_req;
      clear_req = is_clear_desc(rq.seg_base, rq.seg_limit, rq.seg_flags);
      case (rq.req_type)
         REQ_SET_AREA: begin
            if (rq.buffer_fault) begin
               owe_single(ST_FAULT, 0, '0, '0, '0);
            end else if (e == -1 && clear_req) begin
               owe_single(ST_INVALID, 0, '0, '0, '0);
            end else begin
               // free-slot search over the tls window
               if (e == -1) begin
                  for (int c = TLS_FIRST; c <= TLS_LAST && c < TABLE_ENTRIES; c++) begin
                     if (e == -1 && !tbl_used[c]) e = c;
                  end
               end
               if (e == -1) begin
                  owe_single(ST_NOSLOT, 0, '0, '0, '0);
               end else if (!in_tls_range(e)) begin
                  owe_single(ST_INVALID, 0, '0, '0, '0);
               end else begin
                  store_slot(e, rq.seg_base, rq.seg_limit, rq.seg_flags);
                  owe_single(ST_OK, e, '0, '0, '0);
               end
            end
         end
         REQ_GET_AREA: begin
            if (rq.buffer_fault) begin
               owe_single(ST_FAULT, 0, '0, '0, '0);
            end else if (!in_tls_range(e)) begin
               owe_single(ST_INVALID, 0, '0, '0, '0);
            end else if (tbl_used[e]) begin
               owe_single(ST_OK, e, tbl_base[e], tbl_limit[e], tbl_flags[e]);
            end else begin
               owe_single(ST_OK, e, '0, '0, EMPTY_FLAGS);
            end
         end
         REQ_LDT_CALL: begin
            if (rq.ldt_func == LDT_FN_READ) begin
               // whole entries that fit in the budget, at most the table
               n_ent = int'(rq.byte_budget >> 3);
               if (n_ent > TABLE_ENTRIES) n_ent = TABLE_ENTRIES;
               if (rq.byte_budget == 32'd0) begin
                  owe_single(ST_OK, 0, '0, '0, '0);
               end else if (rq.buffer_fault) begin
                  owe_single(ST_FAULT, 0, '0, '0, '0);
               end else if (n_ent == 0) begin
                  owe_single(ST_OK, 0, '0, '0, '0);
               end else begin
                  for (int k = 0; k < n_ent; k++) begin
                     r = '0;
                     words = tbl_used[k] ? encode_desc(tbl_base[k], tbl_limit[k],
                                                       tbl_flags[k]) : 64'd0;
                     r.status        = ST_OK;
                     r.entry_out     = k[5:0];
                     r.bytes_written = 10'((k + 1) * 8);
                     r.word_low      = words[31:0];
                     r.word_high     = words[63:32];
                     r.words_valid   = 1'b1;
                     r.last          = (k == n_ent - 1);
                     awaited_results.push_back(r);
                  end
               end
            end else if (rq.ldt_func != LDT_FN_WRITE_OLD && rq.ldt_func != LDT_FN_WRITE) begin
               owe_single(ST_UNSUP, 0, '0, '0, '0);
            end else if (rq.byte_budget != LDT_WRITE_BYTES) begin
               // size check comes ahead of the fault check
               owe_single(ST_INVALID, 0, '0, '0, '0);
            end else if (rq.buffer_fault) begin
               owe_single(ST_FAULT, 0, '0, '0, '0);
            end else if (e < 0 || e >= TABLE_ENTRIES) begin
               owe_single(ST_INVALID, 0, '0, '0, '0);
            end else begin
               store_slot(e, rq.seg_base, rq.seg_limit, rq.seg_flags);
               owe_single(ST_OK, e, '0, '0, '0);
            end
         end
         default: begin
            // base lookup ignores the fault flag; null selector reads zero
            idx = int'(rq.selector >> 3);
            if ((rq.selector & 16'hfffc) != 16'd0 && idx < TABLE_ENTRIES && tbl_used[idx])
               owe_single(ST_OK, idx, tbl_base[idx], '0, '0);
            else
               owe_single(ST_OK, idx, '0, '0, '0);
         end
      endcase
   endfunction

   function automatic req_item_type mk_req(logic [1:0] kind, int entry, logic [31:0] b,
                                           logic [31:0] l, logic [31:0] f,
                                           logic [31:0] func, logic [31:0] budget,
                                           logic fault, logic [15:0] sel);
      req_item_type it;
      it.req_type     = kind;
      it.entry_req    = entry;
      it.seg_base     = b;
      it.seg_limit    = l;
      it.seg_flags    = f;
      it.ldt_func     = func;
      it.byte_budget  = budget;
      it.buffer_fault = fault;
      it.selector     = sel;
      return it;
   endfunction

   // mostly well-formed requests with random content, some pure noise
   function automatic req_item_type random_request();
      req_item_type it;
      int pick;
      int sub;
      it.req_type     = 2'($urandom_range(0, 3));
      it.entry_req    = $urandom;
      it.seg_base     = $urandom;
      it.seg_limit    = $urandom;
      it.seg_flags    = $urandom;
      it.ldt_func     = $urandom;
      it.byte_budget  = $urandom;
      it.buffer_fault = 1'($urandom_range(0, 1));
      it.selector     = 16'($urandom_range(0, 65535));
      pick = $urandom_range(0, 99);
      if (pick < 8) return it;
      it.buffer_fault = ($urandom_range(0, 19) == 0);
      sub = $urandom_range(0, 9);
      if (pick < 35) begin
         it.req_type = REQ_SET_AREA;
         if (sub < 4) it.entry_req = -1;
         else if (sub < 9) it.entry_req = $urandom_range(TLS_FIRST, TLS_LAST);
         else it.entry_req = $urandom_range(0, 12);
         if ($urandom_range(0, 4) == 0) begin
            it.seg_base  = '0;
            it.seg_limit = '0;
            it.seg_flags = EMPTY_FLAGS;
         end
      end else if (pick < 50) begin
         it.req_type = REQ_GET_AREA;
         if (sub < 8) it.entry_req = $urandom_range(TLS_FIRST, TLS_LAST);
         else if (sub == 8) it.entry_req = $urandom_range(0, 12);
      end else if (pick < 78) begin
         it.req_type = REQ_LDT_CALL;
         if (sub < 4) begin
            it.ldt_func = LDT_FN_READ;
            case ($urandom_range(0, 9))
               0: it.byte_budget = '0;
               1: it.byte_budget = $urandom_range(1, 7);
               2, 3, 4, 5, 6: it.byte_budget = $urandom_range(8, 264);
               7: it.byte_budget = 8 * $urandom_range(1, TABLE_ENTRIES);
               default: ;
            endcase
         end else if (sub < 9) begin
            it.ldt_func = $urandom_range(0, 1) ? LDT_FN_WRITE : LDT_FN_WRITE_OLD;
            it.byte_budget = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32)
                                                         : LDT_WRITE_BYTES;
            case ($urandom_range(0, 9))
               0: it.entry_req = TABLE_ENTRIES;
               1: ;
               default: it.entry_req = $urandom_range(0, TABLE_ENTRIES - 1);
            endcase
            if ($urandom_range(0, 3) == 0) begin
               it.seg_base  = '0;
               it.seg_limit = '0;
               it.seg_flags = EMPTY_FLAGS;
            end
         end else if ($urandom_range(0, 1) == 0) begin
            it.ldt_func = $urandom_range(2, 32'h20);
         end
      end else begin
         it.req_type = REQ_LOOKUP;
         if (sub == 0) it.selector = 16'($urandom_range(0, 3));
         else if (sub > 1)
            it.selector = 16'(($urandom_range(0, TABLE_ENTRIES - 1) << 3)
                              | $urandom_range(0, 7));
      end
      return it;
   endfunction

   // directed items, random items, then release reset and wait for the drain
   initial begin
      for (int i = 0; i < TABLE_ENTRIES; i++) tbl_used[i] = 1'b0;

      // free slot reads as empty, full read of an empty table
      pending_reqs.push_back(mk_req(REQ_GET_AREA, TLS_FIRST, 0, 0, 0, 0, 0, 0, 0));
      pending_reqs.push_back(mk_req(REQ_LDT_CALL, 0, 0, 0, 0, LDT_FN_READ, 256, 0, 0));
      // any free slot with an empty descriptor, and with a fault
      pending_reqs.push_back(mk_req(REQ_SET_AREA, -1, 0, 0, EMPTY_FLAGS, 0, 0, 0, 0));
      pending_reqs.push_back(mk_req(REQ_SET_AREA, -1, 5, 5, 5, 0, 0, 1, 0));
      // fill the tls window: all ones, all zero flags, limit that only looks empty
      pending_reqs.push_back(mk_req(REQ_SET_AREA, -1, '1, '1, '1, 0, 0, 0, 0));
      pending_reqs.push_back(mk_req(REQ_SET_AREA, -1, 0, 0, 0, 0, 0, 0, 0));
      pending_reqs.push_back(mk_req(REQ_SET_AREA, TLS_LAST, 0, 32'h0010_0000, EMPTY_FLAGS,
                                    0, 0, 0, 0));
      pending_reqs.push_back(mk_req(REQ_SET_AREA, -1, 1, 1, 1, 0, 0, 0, 0));
      // outside the tls window
      pending_reqs.push_back(mk_req(REQ_SET_AREA, TLS_LAST + 1, 1, 1, 1, 0, 0, 0, 0));
      pending_reqs.push_back(mk_req(REQ_SET_AREA, 32'h8000_0000, 1, 1, 1, 0, 0, 0, 0));
      pending_reqs.push_back(mk_req(REQ_GET_AREA, TLS_FIRST, 0, 0, 0, 0, 0, 0, 0));
      pending_reqs.push_back(mk_req(REQ_GET_AREA, 32'h7fff_ffff, 0, 0, 0, 0, 0, 0, 0));
      pending_reqs.push_back(mk_req(REQ_GET_AREA, TLS_FIRST + 1, 0, 0, 0, 0, 0, 1, 0));
      pending_reqs.push_back(mk_req(REQ_SET_AREA, TLS_FIRST + 1, 0, 0, EMPTY_FLAGS,
                                    0, 0, 0, 0));
      // ldt writes with both function codes at the table ends
      pending_reqs.push_back(mk_req(REQ_LDT_CALL, 0, 32'hdead_beef, 32'h000a_bcde, 32'h55,
                                    LDT_FN_WRITE, LDT_WRITE_BYTES, 0, 0));
      pending_reqs.push_back(mk_req(REQ_LDT_CALL, TABLE_ENTRIES - 1, 32'h1357_9bdf,
                                    32'h000f_ffff, 32'h2a, LDT_FN_WRITE_OLD,
                                    LDT_WRITE_BYTES, 0, 0));
      pending_reqs.push_back(mk_req(REQ_LDT_CALL, TABLE_ENTRIES, 1, 1, 1, LDT_FN_WRITE,
                                    LDT_WRITE_BYTES, 0, 0));
      // wrong size wins over a fault, then a fault alone
      pending_reqs.push_back(mk_req(REQ_LDT_CALL, 1, 1, 1, 1, LDT_FN_WRITE, 15, 1, 0));
      pending_reqs.push_back(mk_req(REQ_LDT_CALL, 1, 1, 1, 1, LDT_FN_WRITE,
                                    LDT_WRITE_BYTES, 1, 0));
      pending_reqs.push_back(mk_req(REQ_LDT_CALL, 1, 0, 0, 0, 32'h2, 16, 0, 0));
      // reads: zero budget ignores the fault, part of an entry, whole table
      pending_reqs.push_back(mk_req(REQ_LDT_CALL, 0, 0, 0, 0, LDT_FN_READ, 0, 1, 0));
      pending_reqs.push_back(mk_req(REQ_LDT_CALL, 0, 0, 0, 0, LDT_FN_READ, 7, 0, 0));
      pending_reqs.push_back(mk_req(REQ_LDT_CALL, 0, 0, 0, 0, LDT_FN_READ, '1, 0, 0));
      // lookups: null selector, index 0 with a fault, beyond the table, last slot
      pending_reqs.push_back(mk_req(REQ_LOOKUP, 0, 0, 0, 0, 0, 0, 0, 16'h0003));
      pending_reqs.push_back(mk_req(REQ_LOOKUP, 0, 0, 0, 0, 0, 0, 1, 16'h0004));
      pending_reqs.push_back(mk_req(REQ_LOOKUP, 0, 0, 0, 0, 0, 0, 0, 16'hffff));
      pending_reqs.push_back(mk_req(REQ_LOOKUP, 0, 0, 0, 0, 0, 0, 0,
                                    16'((TABLE_ENTRIES - 1) * 8 + 3)));

      for (int i = 0; i < RANDOM_ITEMS; i++) pending_reqs.push_back(random_request());

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || req_valid || awaited_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && awaited_results.size() == 0) begin
         $display("[tls_segment_descriptor_table] OK");
      end else begin
         $display("[tls_segment_descriptor_table] ERROR");
      end
      $finish;
   end

   // request driver: holds a stalled item, otherwise offers the next one or idles
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            compute_table_results(req_item);
            n_taken <= n_taken + 1;
         end
         if (!req_valid || !req_stall) begin
            if (pending_reqs.size() != 0 &&
                !(idling_allowed() && $urandom_range(0, 99) < 10)) begin
               req_item  <= pending_reqs.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall: random gaps plus one long hold-off so the block backs up
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (!hold_done && n_taken >= HOLD_AFTER) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= idling_allowed() && ($urandom_range(0, 99) < 10);
      end
   end

   function automatic string show_rsp(rsp_item_type r);
      return $sformatf("st=%0d ent=%0d bytes=%0d base=%h lim=%h flags=%h lo=%h hi=%h wv=%b last=%b",
                       r.status, r.entry_out, r.bytes_written, r.base_out, r.limit_out,
                       r.flags_out, r.word_low, r.word_high, r.words_valid, r.last);
   endfunction

   function automatic bit same_result(rsp_item_type a, rsp_item_type b);
      return a.status === b.status && a.entry_out === b.entry_out &&
             a.bytes_written === b.bytes_written && a.base_out === b.base_out &&
             a.limit_out === b.limit_out && a.flags_out === b.flags_out &&
             a.word_low === b.word_low && a.word_high === b.word_high &&
             a.words_valid === b.words_valid && a.last === b.last;
   endfunction

   // result checker: every taken result against the oldest one owed
   always @(posedge clock) begin : result_check
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_results.size() == 0) begin
            fail_count <= fail_count + 1;
            if (shown < SHOW_LIMIT) begin
               $display("unexpected result: %s", show_rsp(rsp_item));
               shown <= shown + 1;
            end
         end else begin
            want = awaited_results.pop_front();
            if (!same_result(want, rsp_item)) begin
               fail_count <= fail_count + 1;
               if (shown < SHOW_LIMIT) begin
                  $display("result mismatch\n  want %s\n  got  %s",
                           show_rsp(want), show_rsp(rsp_item));
                  shown <= shown + 1;
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[tls_segment_descriptor_table] ERROR");
         $finish;
      end
   end

endmodule
